[hw/rtl/qubo_pair_flip_local_search_macros.svh]
// Assertion macros for the QUBO pair-flip search block.
// Used by qubo_pair_flip_local_search.sv; needs aclk and aresetn in scope.
`ifndef QUBO_PAIR_FLIP_LOCAL_SEARCH_MACROS_SVH
`define QUBO_PAIR_FLIP_LOCAL_SEARCH_MACROS_SVH

// same-cycle implication
`define QPFLS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QPFLS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/qpfls_pkg.sv]
// Package for the QUBO pair-flip search block: widths, memory words, codes.
// No dependencies.
package qpfls_pkg;

    localparam int MAX_VARS  = 256;
    localparam int MAX_PAIRS = 1024;
    localparam int COEF_BITS = 24;
    localparam int GAIN_BITS = 40;
    localparam int OBJ_BITS  = 48;
    localparam int BEN_BITS  = GAIN_BITS + 2;
    localparam int VAR_AW    = $clog2(MAX_VARS);
    localparam int PAIR_AW   = $clog2(MAX_PAIRS);
    localparam int MOVE_BITS = 16;

    // operation codes
    localparam logic [1:0] OP_LOAD_VAR  = 2'd0;
    localparam logic [1:0] OP_LOAD_PAIR = 2'd1;
    localparam logic [1:0] OP_RUN       = 2'd2;
    localparam logic [1:0] OP_READ_VAR  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_MIN_GAIN  = 2'd1;
    localparam logic [1:0] CFG_NUM_VARS  = 2'd2;
    localparam logic [1:0] CFG_NUM_PAIRS = 2'd3;

    // result kinds
    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic                        val;
        logic signed [COEF_BITS-1:0] lin;
        logic signed [GAIN_BITS-1:0] gain;
    } var_word_t;

    typedef struct packed {
        logic [VAR_AW-1:0]           vi;
        logic [VAR_AW-1:0]           vj;
        logic signed [COEF_BITS-1:0] q;
    } pair_word_t;

endpackage

[hw/rtl/qubo_pair_flip_local_search.sv]
// QUBO pair-flip local search, top level: sequencer, variable and pair memories.
// Depends on qpfls_pkg and qubo_pair_flip_local_search_macros.svh.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------------
//  s_       | in  | s_tvalid / s_tready | tuser: operation; tdata: item fields
//  m_       | out | m_tvalid / m_tready | tuser: result_kind; tdata: result fields
//  cfg_     | in  | cfg_we              | cfg_addr: register, cfg_wdata: value
//
// A pair load is written straight from idle; a variable load passes through a
// write step, a read through the output slot. A run sets up gains over all 256
// variable slots, adds pair terms, then scans pair rounds and, per move, walks
// the pair memory once for each of the two flipped variables.
// Reset (aresetn low, synchronous) clears control state, objective and moves;
// memory contents are undefined until loaded. A stalled result holds the
// output register; no new request is taken until the sequencer is back idle.
`include "qubo_pair_flip_local_search_macros.svh"

module qubo_pair_flip_local_search (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: var_index[7:0], other_index[15:8], coef[39:16], init_value[40],
    //        pair_slot[50:41], zero pad
    input  logic [55:0]  s_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: objective[47:0], move_count[63:48], var_value[64],
    //        var_gain[104:65], zero pad
    output logic [111:0] m_tdata,
    // tuser: result_kind[0]
    output logic [0:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [22:0]  cfg_wdata
);

    localparam int VW = qpfls_pkg::VAR_AW;
    localparam int PW = qpfls_pkg::PAIR_AW;
    localparam int CB = qpfls_pkg::COEF_BITS;
    localparam int GB = qpfls_pkg::GAIN_BITS;
    localparam int OB = qpfls_pkg::OBJ_BITS;
    localparam int BB = qpfls_pkg::BEN_BITS;
    localparam int MB = qpfls_pkg::MOVE_BITS;

    // sequencer states
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_LV_WR   = 5'd1;
    localparam logic [4:0] ST_RD_OUT  = 5'd2;
    localparam logic [4:0] ST_INIT_RD = 5'd3;
    localparam logic [4:0] ST_INIT_WR = 5'd4;
    localparam logic [4:0] ST_PS_RD   = 5'd5;
    localparam logic [4:0] ST_PS_VR   = 5'd6;
    localparam logic [4:0] ST_PS_WI   = 5'd7;
    localparam logic [4:0] ST_PS_WJ   = 5'd8;
    localparam logic [4:0] ST_SR_RD   = 5'd9;
    localparam logic [4:0] ST_SR_VR   = 5'd10;
    localparam logic [4:0] ST_SR_EV   = 5'd11;
    localparam logic [4:0] ST_SR_END  = 5'd12;
    localparam logic [4:0] ST_FU_RD   = 5'd13;
    localparam logic [4:0] ST_FU_WR   = 5'd14;
    localparam logic [4:0] ST_FP_RD   = 5'd15;
    localparam logic [4:0] ST_FP_VR   = 5'd16;
    localparam logic [4:0] ST_FP_WR   = 5'd17;
    localparam logic [4:0] ST_OUT_RUN = 5'd18;

    // input fields
    logic [1:0]           in_op;
    logic [VW-1:0]        in_vi, in_oi;
    logic signed [CB-1:0] in_coef;
    logic                 in_init;
    logic [PW-1:0]        in_slot;
    logic                 in_acc;

    assign in_op   = s_tuser;
    assign in_vi   = s_tdata[7:0];
    assign in_oi   = s_tdata[15:8];
    assign in_coef = s_tdata[39:16];
    assign in_init = s_tdata[40];
    assign in_slot = s_tdata[50:41];
    assign in_acc  = s_tvalid && s_tready;

    // configuration
    logic        mode_reg;
    logic [22:0] min_gain_reg;
    logic [8:0]  nv_reg;
    logic [10:0] np_reg;
    logic [8:0]  nv_eff;
    logic [10:0] np_eff;

    assign nv_eff = (nv_reg > 9'(qpfls_pkg::MAX_VARS)) ? 9'(qpfls_pkg::MAX_VARS) : nv_reg;
    assign np_eff = (np_reg > 11'(qpfls_pkg::MAX_PAIRS)) ? 11'(qpfls_pkg::MAX_PAIRS) : np_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b0;
            min_gain_reg <= '0;
            nv_reg       <= 9'(qpfls_pkg::MAX_VARS);
            np_reg       <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                qpfls_pkg::CFG_MODE:      mode_reg     <= cfg_wdata[0];
                qpfls_pkg::CFG_MIN_GAIN:  min_gain_reg <= cfg_wdata;
                qpfls_pkg::CFG_NUM_VARS:  nv_reg       <= cfg_wdata[8:0];
                qpfls_pkg::CFG_NUM_PAIRS: np_reg       <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // memories: variables (two read ports, one write), pairs (one read port, one write)
    qpfls_pkg::var_word_t  vmem [qpfls_pkg::MAX_VARS];
    qpfls_pkg::pair_word_t pmem [qpfls_pkg::MAX_PAIRS];
    qpfls_pkg::var_word_t  va_q, vb_q, v_wdata;
    qpfls_pkg::pair_word_t p_q;
    logic [VW-1:0]         va_addr, vb_addr, v_waddr;
    logic                  v_we, p_we;
    logic [PW-1:0]         p_addr;

    always_ff @(posedge aclk) begin
        if (v_we) begin
            vmem[v_waddr] <= v_wdata;
        end
        va_q <= vmem[va_addr];
        vb_q <= vmem[vb_addr];
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            pmem[in_slot] <= '{vi: in_vi, vj: in_oi, q: in_coef};
        end
        p_q <= pmem[p_addr];
    end

    // sequencer registers
    logic [4:0]           state_reg, state_next;
    logic [VW-1:0]        vcnt_reg, vcnt_next;
    logic [10:0]          scnt_reg, scnt_next;
    logic signed [OB-1:0] obj_reg, obj_next;
    logic [MB-1:0]        moves_reg, moves_next;
    logic signed [BB-1:0] best_reg, best_next;
    logic [VW-1:0]        mv_i_reg, mv_i_next, mv_j_reg, mv_j_next;
    logic [VW-1:0]        u_reg, u_next;
    logic                 phase_reg, phase_next;
    logic [VW-1:0]        pi_reg, pi_next, pj_reg, pj_next;
    logic signed [CB-1:0] pq_reg, pq_next;
    qpfls_pkg::var_word_t wj_reg, wj_next;
    logic [VW-1:0]        vi_reg, vi_next;
    logic signed [CB-1:0] coef_reg, coef_next;
    logic                 init_reg, init_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [111:0]         m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    // datapath terms
    logic                 p_active, out_free, scan_done;
    logic signed [CB:0]   dq;
    logic signed [GB-1:0] dg;
    logic signed [BB-1:0] benefit, thr;
    qpfls_pkg::var_word_t w_u, w_v;

    assign p_active  = ({1'b0, pi_reg} < nv_eff) && ({1'b0, pj_reg} < nv_eff)
                       && (pi_reg != pj_reg);
    assign dq        = {pq_reg, 1'b0};
    assign dg        = GB'(dq);
    assign benefit   = (va_q.val == vb_q.val)
                       ? (BB'(va_q.gain) + BB'(vb_q.gain) + BB'(dq))
                       : (BB'(va_q.gain) + BB'(vb_q.gain) - BB'(dq));
    assign thr       = BB'({1'b0, min_gain_reg});
    assign out_free  = !m_tvalid_reg || m_tready;
    assign scan_done = (scnt_reg >= np_eff);
    assign w_u       = (pi_reg == u_reg) ? va_q : vb_q;
    assign w_v       = (pi_reg == u_reg) ? vb_q : va_q;

    always_comb begin
        state_next    = state_reg;
        vcnt_next     = vcnt_reg;
        scnt_next     = scnt_reg;
        obj_next      = obj_reg;
        moves_next    = moves_reg;
        best_next     = best_reg;
        mv_i_next     = mv_i_reg;
        mv_j_next     = mv_j_reg;
        u_next        = u_reg;
        phase_next    = phase_reg;
        pi_next       = pi_reg;
        pj_next       = pj_reg;
        pq_next       = pq_reg;
        wj_next       = wj_reg;
        vi_next       = vi_reg;
        coef_next     = coef_reg;
        init_next     = init_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        va_addr       = pi_reg;
        vb_addr       = pj_reg;
        v_we          = 1'b0;
        v_waddr       = pi_reg;
        v_wdata       = va_q;
        p_we          = 1'b0;
        p_addr        = scnt_reg[PW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                va_addr = in_vi;
                if (in_acc) begin
                    vi_next   = in_vi;
                    coef_next = in_coef;
                    init_next = in_init;
                    unique case (in_op)
                        qpfls_pkg::OP_LOAD_VAR:  state_next = ST_LV_WR;
                        qpfls_pkg::OP_LOAD_PAIR: p_we = 1'b1;
                        qpfls_pkg::OP_RUN: begin
                            obj_next   = '0;
                            moves_next = '0;
                            vcnt_next  = '0;
                            state_next = ST_INIT_RD;
                        end
                        qpfls_pkg::OP_READ_VAR:  state_next = ST_RD_OUT;
                        default: ;
                    endcase
                end
            end
            ST_LV_WR: begin
                // keep the stale gain, replace value and linear term
                v_we       = 1'b1;
                v_waddr    = vi_reg;
                v_wdata    = '{val: init_reg, lin: coef_reg, gain: va_q.gain};
                state_next = ST_IDLE;
            end
            ST_RD_OUT: begin
                va_addr = vi_reg;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = qpfls_pkg::KIND_READ;
                    m_tdata_next  = {7'd0, va_q.gain, va_q.val, moves_reg, obj_reg};
                    state_next    = ST_IDLE;
                end else begin
                    // re-read each cycle so the data is valid when space opens
                    state_next = ST_RD_OUT;
                end
            end
            ST_INIT_RD: begin
                va_addr    = vcnt_reg;
                state_next = ST_INIT_WR;
            end
            ST_INIT_WR: begin
                v_we    = 1'b1;
                v_waddr = vcnt_reg;
                v_wdata = va_q;
                if ({1'b0, vcnt_reg} < nv_eff) begin
                    if (va_q.val) begin
                        v_wdata.gain = -GB'(va_q.lin);
                        obj_next     = obj_reg + OB'(va_q.lin);
                    end else begin
                        v_wdata.gain = GB'(va_q.lin);
                    end
                end else begin
                    v_wdata.gain = '0;
                end
                if (vcnt_reg == VW'(qpfls_pkg::MAX_VARS - 1)) begin
                    scnt_next  = '0;
                    state_next = ST_PS_RD;
                end else begin
                    vcnt_next  = vcnt_reg + 1'b1;
                    state_next = ST_INIT_RD;
                end
            end
            ST_PS_RD: begin
                if (scan_done) begin
                    scnt_next  = '0;
                    best_next  = '0;
                    state_next = ST_SR_RD;
                end else begin
                    state_next = ST_PS_VR;
                end
            end
            ST_PS_VR: begin
                va_addr    = p_q.vi;
                vb_addr    = p_q.vj;
                pi_next    = p_q.vi;
                pj_next    = p_q.vj;
                pq_next    = p_q.q;
                state_next = ST_PS_WI;
            end
            ST_PS_WI: begin
                v_we    = 1'b1;
                v_waddr = pi_reg;
                v_wdata = va_q;
                wj_next = vb_q;
                if (p_active) begin
                    if (va_q.val && vb_q.val) begin
                        obj_next     = obj_reg + OB'(dq);
                        v_wdata.gain = va_q.gain - dg;
                        wj_next.gain = vb_q.gain - dg;
                    end else if (va_q.val) begin
                        wj_next.gain = vb_q.gain + dg;
                    end else if (vb_q.val) begin
                        v_wdata.gain = va_q.gain + dg;
                    end
                end
                state_next = ST_PS_WJ;
            end
            ST_PS_WJ: begin
                v_we       = 1'b1;
                v_waddr    = pj_reg;
                v_wdata    = wj_reg;
                scnt_next  = scnt_reg + 1'b1;
                state_next = ST_PS_RD;
            end
            ST_SR_RD: begin
                state_next = scan_done ? ST_SR_END : ST_SR_VR;
            end
            ST_SR_VR: begin
                va_addr    = p_q.vi;
                vb_addr    = p_q.vj;
                pi_next    = p_q.vi;
                pj_next    = p_q.vj;
                pq_next    = p_q.q;
                state_next = ST_SR_EV;
            end
            ST_SR_EV: begin
                scnt_next  = scnt_reg + 1'b1;
                state_next = ST_SR_RD;
                if (p_active) begin
                    if (!mode_reg) begin
                        if (benefit > best_reg) begin
                            best_next = benefit;
                            mv_i_next = pi_reg;
                            mv_j_next = pj_reg;
                        end
                    end else if (benefit > thr) begin
                        // first mode: take it now, rescan after the move
                        mv_i_next  = pi_reg;
                        mv_j_next  = pj_reg;
                        u_next     = pi_reg;
                        phase_next = 1'b0;
                        state_next = ST_FU_RD;
                    end
                end
            end
            ST_SR_END: begin
                if (!mode_reg && (best_reg > thr)) begin
                    u_next     = mv_i_reg;
                    phase_next = 1'b0;
                    state_next = ST_FU_RD;
                end else begin
                    state_next = ST_OUT_RUN;
                end
            end
            ST_FU_RD: begin
                va_addr    = u_reg;
                state_next = ST_FU_WR;
            end
            ST_FU_WR: begin
                v_we         = 1'b1;
                v_waddr      = u_reg;
                v_wdata      = va_q;
                v_wdata.val  = ~va_q.val;
                v_wdata.gain = -va_q.gain;
                obj_next     = obj_reg + OB'(va_q.gain);
                scnt_next    = '0;
                state_next   = ST_FP_RD;
            end
            ST_FP_RD: begin
                if (scan_done) begin
                    if (!phase_reg) begin
                        u_next     = mv_j_reg;
                        phase_next = 1'b1;
                        state_next = ST_FU_RD;
                    end else begin
                        if (moves_reg != '1) begin
                            moves_next = moves_reg + 1'b1;
                        end
                        scnt_next  = '0;
                        best_next  = '0;
                        state_next = ST_SR_RD;
                    end
                end else begin
                    state_next = ST_FP_VR;
                end
            end
            ST_FP_VR: begin
                va_addr    = p_q.vi;
                vb_addr    = p_q.vj;
                pi_next    = p_q.vi;
                pj_next    = p_q.vj;
                pq_next    = p_q.q;
                state_next = ST_FP_WR;
            end
            ST_FP_WR: begin
                // neighbor of the flipped variable takes the pair term change
                v_waddr = (pi_reg == u_reg) ? pj_reg : pi_reg;
                v_wdata = w_v;
                if (p_active && ((pi_reg == u_reg) || (pj_reg == u_reg))) begin
                    v_we         = 1'b1;
                    v_wdata.gain = (w_u.val == w_v.val) ? (w_v.gain - dg) : (w_v.gain + dg);
                end
                scnt_next  = scnt_reg + 1'b1;
                state_next = ST_FP_RD;
            end
            ST_OUT_RUN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = qpfls_pkg::KIND_RUN;
                    m_tdata_next  = {7'd0, GB'(0), 1'b0, moves_reg, obj_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            obj_reg      <= '0;
            moves_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            vcnt_reg     <= '0;
            scnt_reg     <= '0;
            phase_reg    <= 1'b0;
            best_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            obj_reg      <= obj_next;
            moves_reg    <= moves_next;
            m_tvalid_reg <= m_tvalid_next;
            vcnt_reg     <= vcnt_next;
            scnt_reg     <= scnt_next;
            phase_reg    <= phase_next;
            best_reg     <= best_next;
        end
        mv_i_reg    <= mv_i_next;
        mv_j_reg    <= mv_j_next;
        u_reg       <= u_next;
        pi_reg      <= pi_next;
        pj_reg      <= pj_next;
        pq_reg      <= pq_next;
        wj_reg      <= wj_next;
        vi_reg      <= vi_next;
        coef_reg    <= coef_next;
        init_reg    <= init_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // assertions
    `QPFLS_ASSERT_NXT(a_moves_monotonic, state_reg != ST_IDLE,
        moves_reg >= $past(moves_reg), "move count dropped during a run")
    `QPFLS_ASSERT_IMP(a_var_write_state, v_we,
        state_reg == ST_LV_WR || state_reg == ST_INIT_WR || state_reg == ST_PS_WI ||
        state_reg == ST_PS_WJ || state_reg == ST_FU_WR || state_reg == ST_FP_WR,
        "variable memory written outside a write step")
    `QPFLS_ASSERT_NXT(a_first_mode_done, state_reg == ST_SR_END && mode_reg,
        state_reg == ST_OUT_RUN, "first-mode scan end did not finish the run")
    `QPFLS_ASSERT_IMP(a_pair_write_idle, p_we,
        state_reg == ST_IDLE && in_acc, "pair memory written outside a load request")

endmodule
